@@ sv/chs_pkg.sv @@
// Shared types and constants for the chained hash set.
package chs_pkg;

  localparam int TOTAL_W = 11;
  localparam int HASH_W  = 16;

  localparam logic [63:0] MIX_C1 = 64'hff51afd7ed558ccd;
  localparam logic [63:0] MIX_C2 = 64'hc4ceb9fe1a85ec53;
  localparam int          MIX_SH = 33;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_QUERY  = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_CLEAR  = 2'd3
  } chs_cmd_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [63:0] key;
  } chs_in_t;

  typedef struct packed {
    logic               was_present;
    logic               changed;
    logic               store_full;
    logic [TOTAL_W-1:0] element_total;
  } chs_out_t;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [63:0]       key;
    logic [HASH_W-1:0] hash;
  } chs_job_t;

  typedef enum logic [3:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_HEAD,
    ST_CHECK,
    ST_NODE,
    ST_ACT,
    ST_FREE,
    ST_WRITE,
    ST_UNLINK,
    ST_RELINK
  } chs_state_t;

endpackage

@@ sv/chs_hash.sv @@
// Front end: accepts words and computes the finaliser hash with one shared 32x32 multiplier.
module chs_hash import chs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  input  chs_in_t  in_data,
  output logic     busy,
  output logic     push,
  output chs_job_t push_job,
  input  logic     q_full
);

  logic        busy_r, busy_nxt;
  logic [2:0]  ph_r, ph_nxt;
  logic [63:0] x_r, x_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic [63:0] key_r;
  logic [1:0]  cmd_r;
  logic [63:0] cst, fin;
  logic [31:0] mul_a, mul_c;
  logic [63:0] prod;

  assign cst   = ph_r[2] ? MIX_C2 : MIX_C1;
  assign mul_a = (ph_r[1:0] == 2'd2) ? x_r[63:32] : x_r[31:0];
  assign mul_c = (ph_r[1:0] == 2'd1) ? cst[63:32] : cst[31:0];
  assign prod  = 64'(mul_a) * 64'(mul_c);
  assign fin   = acc_r ^ (acc_r >> MIX_SH);

  assign busy = busy_r;
  assign push = busy_r && (ph_r == 3'd7) && !q_full;
  assign push_job = '{cmd: cmd_r, key: key_r, hash: fin[HASH_W-1:0]};

  always_comb begin
    busy_nxt = busy_r;
    ph_nxt   = ph_r;
    x_nxt    = x_r;
    acc_nxt  = acc_r;
    if (!busy_r) begin
      if (start) begin
        busy_nxt = 1'b1;
        ph_nxt   = 3'd0;
        x_nxt    = in_data.key ^ (in_data.key >> MIX_SH);
      end
    end else begin
      case (ph_r[1:0])
        2'd0: acc_nxt = prod;
        2'd1, 2'd2: acc_nxt = acc_r + {prod[31:0], 32'b0};
        default: begin
          if (!ph_r[2]) x_nxt = fin;
        end
      endcase
      if (ph_r != 3'd7) ph_nxt = ph_r + 3'd1;
      else if (!q_full) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ph_r   <= 3'd0;
    end else begin
      busy_r <= busy_nxt;
      ph_r   <= ph_nxt;
    end
    x_r   <= x_nxt;
    acc_r <= acc_nxt;
    if (start && !busy_r) begin
      key_r <= in_data.key;
      cmd_r <= in_data.cmd;
    end
  end

endmodule

@@ sv/chs_fifo.sv @@
// Two-entry queue of hashed jobs between front and back.
module chs_fifo import chs_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  chs_job_t push_job,
  input  logic     pop,
  output chs_job_t head_job,
  output logic     empty,
  output logic     full
);

  chs_job_t   mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;

  assign empty    = (cnt_r == 2'd0);
  assign full     = (cnt_r == 2'd2);
  assign head_job = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(pop);
    end
    if (push) mem_r[wp_r] <= push_job;
  end

endmodule

@@ sv/chs_store.sv @@
// Back end: bucket heads, node store, free list and the chain walk sequencer.
module chs_store import chs_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int BUCKETS  = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  chs_job_t head_job,
  input  logic     q_empty,
  output logic     pop,
  output logic     out_strobe,
  output chs_out_t out_data
);

  localparam int IW = $clog2(CAPACITY + 1);
  localparam int AW = $clog2(CAPACITY);
  localparam int BW = $clog2(BUCKETS);
  localparam logic [IW-1:0] NIL = IW'(CAPACITY);

  logic [IW-1:0] heads [BUCKETS];
  logic [63:0]   keys  [CAPACITY];
  logic [IW-1:0] links [CAPACITY];

  chs_state_t st_r, st_nxt;
  chs_job_t   job_r, job_nxt;
  logic [IW-1:0] cur_r, cur_nxt, prev_r, prev_nxt, steps_r, steps_nxt;
  logic [IW-1:0] hval_r, hval_nxt, node_r, node_nxt, nlink_r, nlink_nxt;
  logic [IW-1:0] new_r, new_nxt, free_r, free_nxt, fill_r, fill_nxt, cnt_r, cnt_nxt;
  logic          found_r, found_nxt;
  logic [BW-1:0] sweep_r, sweep_nxt;
  logic          strobe_r, strobe_nxt;
  chs_out_t      out_r, out_nxt;

  logic [BW-1:0] hd_addr;
  logic [AW-1:0] rd_addr;
  logic [IW-1:0] head_q, link_q;
  logic [63:0]   key_q;
  logic          hw_en, lw_en, kw_en;
  logic [BW-1:0] hw_addr;
  logic [IW-1:0] hw_data, lw_data;
  logic [AW-1:0] lw_addr;

  always_comb begin
    st_nxt = st_r; job_nxt = job_r; cur_nxt = cur_r; prev_nxt = prev_r;
    steps_nxt = steps_r; hval_nxt = hval_r; node_nxt = node_r; nlink_nxt = nlink_r;
    new_nxt = new_r; free_nxt = free_r; fill_nxt = fill_r; cnt_nxt = cnt_r;
    found_nxt = found_r; sweep_nxt = sweep_r;
    strobe_nxt = 1'b0;
    out_nxt = '0;
    pop = 1'b0;
    hd_addr = head_job.hash[BW-1:0];
    rd_addr = cur_r[AW-1:0];
    hw_en = 1'b0; hw_addr = job_r.hash[BW-1:0]; hw_data = new_r;
    lw_en = 1'b0; lw_addr = new_r[AW-1:0]; lw_data = hval_r;
    kw_en = 1'b0;
    case (st_r)
      ST_SWEEP: begin
        hw_en = 1'b1; hw_addr = sweep_r; hw_data = NIL;
        sweep_nxt = sweep_r + BW'(1);
        if (sweep_r == BW'(BUCKETS - 1)) st_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          job_nxt = head_job;
          if (head_job.cmd == CMD_CLEAR) begin
            strobe_nxt = 1'b1;
            out_nxt.changed = (cnt_r != '0);
            free_nxt = NIL; fill_nxt = '0; cnt_nxt = '0; sweep_nxt = '0;
            st_nxt = ST_SWEEP;
          end else begin
            st_nxt = ST_HEAD;
          end
        end
      end
      ST_HEAD: begin
        cur_nxt = head_q; hval_nxt = head_q; prev_nxt = NIL; steps_nxt = '0;
        st_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (cur_r >= NIL || steps_r >= NIL) begin
          found_nxt = 1'b0; st_nxt = ST_ACT;
        end else begin
          st_nxt = ST_NODE;
        end
      end
      ST_NODE: begin
        if (key_q == job_r.key) begin
          found_nxt = 1'b1; node_nxt = cur_r; nlink_nxt = link_q; st_nxt = ST_ACT;
        end else begin
          prev_nxt = cur_r; cur_nxt = link_q; steps_nxt = steps_r + IW'(1);
          st_nxt = ST_CHECK;
        end
      end
      ST_ACT: begin
        st_nxt = ST_IDLE;
        case (job_r.cmd)
          CMD_ADD: begin
            if (found_r) begin
              strobe_nxt = 1'b1; out_nxt.was_present = 1'b1;
            end else if (free_r < NIL) begin
              rd_addr = free_r[AW-1:0]; new_nxt = free_r; st_nxt = ST_FREE;
            end else if (fill_r < NIL) begin
              new_nxt = fill_r; fill_nxt = fill_r + IW'(1); st_nxt = ST_WRITE;
            end else begin
              strobe_nxt = 1'b1; out_nxt.store_full = 1'b1;
            end
          end
          CMD_QUERY: begin
            strobe_nxt = 1'b1; out_nxt.was_present = found_r;
          end
          CMD_REMOVE: begin
            if (found_r) st_nxt = ST_UNLINK;
            else strobe_nxt = 1'b1;
          end
          default: st_nxt = ST_IDLE;
        endcase
      end
      ST_FREE: begin
        free_nxt = link_q; st_nxt = ST_WRITE;
      end
      ST_WRITE: begin
        kw_en = 1'b1; lw_en = 1'b1; hw_en = 1'b1;
        cnt_nxt = cnt_r + IW'(1);
        strobe_nxt = 1'b1; out_nxt.changed = 1'b1;
        st_nxt = ST_IDLE;
      end
      ST_UNLINK: begin
        if (prev_r < NIL) begin
          lw_en = 1'b1; lw_addr = prev_r[AW-1:0]; lw_data = nlink_r;
        end else begin
          hw_en = 1'b1; hw_data = nlink_r;
        end
        st_nxt = ST_RELINK;
      end
      ST_RELINK: begin
        lw_en = 1'b1; lw_addr = node_r[AW-1:0]; lw_data = free_r;
        free_nxt = node_r;
        if (cnt_r != '0) cnt_nxt = cnt_r - IW'(1);
        strobe_nxt = 1'b1; out_nxt.was_present = 1'b1; out_nxt.changed = 1'b1;
        st_nxt = ST_IDLE;
      end
      default: st_nxt = ST_IDLE;
    endcase
    out_nxt.element_total = TOTAL_W'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    head_q <= heads[hd_addr];
    key_q  <= keys[rd_addr];
    link_q <= links[rd_addr];
    if (hw_en) heads[hw_addr] <= hw_data;
    if (lw_en) links[lw_addr] <= lw_data;
    if (kw_en) keys[new_r[AW-1:0]] <= job_r.key;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r     <= ST_SWEEP;
      sweep_r  <= '0;
      free_r   <= NIL;
      fill_r   <= '0;
      cnt_r    <= '0;
      strobe_r <= 1'b0;
    end else begin
      st_r     <= st_nxt;
      sweep_r  <= sweep_nxt;
      free_r   <= free_nxt;
      fill_r   <= fill_nxt;
      cnt_r    <= cnt_nxt;
      strobe_r <= strobe_nxt;
    end
    job_r <= job_nxt; cur_r <= cur_nxt; prev_r <= prev_nxt; steps_r <= steps_nxt;
    hval_r <= hval_nxt; node_r <= node_nxt; nlink_r <= nlink_nxt; new_r <= new_nxt;
    found_r <= found_nxt; out_r <= out_nxt;
  end

  assign out_strobe = strobe_r;
  assign out_data   = out_r;

endmodule

@@ sv/chained_hash_set.sv @@
// Top level of the chained hash set: hash front end, job queue, store back end.
//  channel  | handshake        | word
//  input    | start / busy     | in_data  (cmd, key)
//  result   | out_strobe       | out_data (was_present, changed, store_full, element_total)
// Hashing uses the shared 32x32 multiplier; the back end walks the bucket chain node by node,
// then takes a free node and writes it for an add, or unlinks and relinks the node for a remove.
// Reset and clear sweep the bucket heads, one per cycle;
// the queue fills and busy rises meanwhile. Results are single-cycle strobes.
module chained_hash_set import chs_pkg::*; #(
  parameter int CAPACITY = 1024,
  parameter int BUCKETS  = 2048
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  chs_in_t  in_data,
  output logic     out_strobe,
  output chs_out_t out_data
);

  logic     push, pop, q_empty, q_full;
  chs_job_t push_job, head_job;

  chs_hash u_hash (
    .clk, .rst_n, .start, .in_data, .busy, .push, .push_job, .q_full
  );

  chs_fifo u_fifo (
    .clk, .rst_n, .push, .push_job, .pop, .head_job, .empty(q_empty), .full(q_full)
  );

  chs_store #(.CAPACITY(CAPACITY), .BUCKETS(BUCKETS)) u_store (
    .clk, .rst_n, .head_job, .q_empty, .pop, .out_strobe, .out_data
  );

endmodule

@@ tb/chained_hash_set_test.sv @@
// Testbench for the chained hash set: random and directed commands against a set model.
`timescale 1ns / 100ps

module chained_hash_set_test;
  import chs_pkg::*;

  localparam int CAP   = 1024;
  localparam int NBKT  = 2048;
  localparam int LIMIT = 4000000;

  logic     clk;
  logic     rst_n;
  logic     start;
  logic     busy;
  chs_in_t  in_data;
  logic     out_strobe;
  chs_out_t out_data;

  chained_hash_set dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_strobe(out_strobe), .out_data(out_data)
  );

  // set model
  int unsigned     head_of[NBKT];
  logic [63:0]     key_of[CAP];
  int unsigned     link_of[CAP];
  int unsigned     free_top;
  int unsigned     fill_top;
  int unsigned     held;

  chs_in_t  pending[$];
  chs_out_t expected[$];
  logic [63:0] live_keys[$];
  int errors;
  int phase;
  int cycles;
  bit accepted;

  function automatic int unsigned bucket_of(logic [63:0] k);
    logic [63:0] h;
    h = k;
    h = h ^ (h >> MIX_SH);
    h = h * MIX_C1;
    h = h ^ (h >> MIX_SH);
    h = h * MIX_C2;
    h = h ^ (h >> MIX_SH);
    return 32'(h % NBKT);
  endfunction

  function automatic chs_out_t predict_set(chs_in_t w);
    chs_out_t r;
    int unsigned b, cur, prv, hit, n, steps;
    r = '0;
    if (chs_cmd_t'(w.cmd) == CMD_CLEAR) begin
      r.changed = (held != 0);
      foreach (head_of[i]) head_of[i] = CAP;
      free_top = CAP;
      fill_top = 0;
      held = 0;
    end else begin
      b = bucket_of(w.key);
      cur = head_of[b];
      prv = CAP;
      hit = CAP;
      steps = 0;
      while (cur < CAP && steps < CAP) begin
        if (key_of[cur] == w.key) begin
          hit = cur;
          break;
        end
        prv = cur;
        cur = link_of[cur];
        steps++;
      end
      r.was_present = (hit < CAP);
      if (chs_cmd_t'(w.cmd) == CMD_ADD && hit == CAP) begin
        n = CAP;
        if (free_top < CAP) begin
          n = free_top;
          free_top = link_of[n];
        end else if (fill_top < CAP) begin
          n = fill_top;
          fill_top++;
        end
        if (n < CAP) begin
          key_of[n] = w.key;
          link_of[n] = head_of[b];
          head_of[b] = n;
          held++;
          r.changed = 1;
        end else r.store_full = 1;
      end else if (chs_cmd_t'(w.cmd) == CMD_REMOVE && hit < CAP) begin
        if (prv < CAP) link_of[prv] = link_of[hit];
        else head_of[b] = link_of[hit];
        link_of[hit] = free_top;
        free_top = hit;
        if (held > 0) held--;
        r.changed = 1;
      end
    end
    r.element_total = held[TOTAL_W-1:0];
    return r;
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
    errors++;
  endtask

  task automatic queue_word(chs_cmd_t c, logic [63:0] k);
    chs_in_t w;
    w.cmd = c;
    w.key = k;
    pending.push_back(w);
  endtask

  function automatic logic [63:0] rand_key();
    return {$urandom, $urandom};
  endfunction

  // keys drawn from a small pool so that hits and removes are common
  function automatic logic [63:0] pool_key();
    if (live_keys.size() > 0 && $urandom_range(0, 1))
      return live_keys[$urandom_range(0, live_keys.size() - 1)];
    return rand_key();
  endfunction

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // driver: moves on only once the monitor has seen the word taken
  always @(negedge clk) begin
    int idle_pct;
    idle_pct = (phase == 0) ? 34 : (phase == 1) ? 77 : 0;
    if (!rst_n) start <= 0;
    else if (accepted || !start) begin
      if (accepted) void'(pending.pop_front());
      if (pending.size() > 0 && $urandom_range(0, 99) >= idle_pct) begin
        in_data <= pending[0];
        start <= 1;
      end else start <= 0;
    end
  end

  // monitor: accepted commands feed the model, results are checked in order
  always @(posedge clk) begin
    chs_out_t e;
    if (rst_n) begin
      cycles++;
      accepted = start && !busy;
      if (out_strobe) begin
        if (expected.size() == 0) report("unexpected word", 64'(out_data), 64'(0));
        else begin
          e = expected.pop_front();
          if (out_data.was_present !== e.was_present)
            report("was_present", 64'(out_data.was_present), 64'(e.was_present));
          if (out_data.changed !== e.changed)
            report("changed", 64'(out_data.changed), 64'(e.changed));
          if (out_data.store_full !== e.store_full)
            report("store_full", 64'(out_data.store_full), 64'(e.store_full));
          if (out_data.element_total !== e.element_total)
            report("element_total", 64'(out_data.element_total), 64'(e.element_total));
        end
      end
      if (accepted) expected.push_back(predict_set(in_data));
      if (cycles > LIMIT) begin
        $display("chained_hash_set_test: errors");
        $finish;
      end
    end else accepted = 0;
  end

  initial begin
    logic [63:0] k;
    errors = 0;
    cycles = 0;
    phase = 0;
    start = 0;
    in_data = '0;
    rst_n = 0;
    foreach (head_of[i]) head_of[i] = CAP;
    free_top = CAP;
    fill_top = 0;
    held = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1;

    // directed: extremes, every command, duplicates, absent removes, empty clear
    queue_word(CMD_CLEAR, 64'h0);
    queue_word(CMD_QUERY, 64'h0);
    queue_word(CMD_ADD, 64'h0);
    queue_word(CMD_ADD, 64'h0);
    queue_word(CMD_ADD, '1);
    queue_word(CMD_QUERY, '1);
    queue_word(CMD_ADD, 64'h8000_0000_0000_0000);
    queue_word(CMD_ADD, 64'h5555_5555_5555_5555);
    queue_word(CMD_ADD, 64'haaaa_aaaa_aaaa_aaaa);
    queue_word(CMD_REMOVE, 64'h1234);
    queue_word(CMD_REMOVE, 64'h0);
    queue_word(CMD_QUERY, 64'h0);
    queue_word(CMD_ADD, 64'h1);
    queue_word(CMD_REMOVE, '1);
    queue_word(CMD_REMOVE, 64'h5555_5555_5555_5555);
    queue_word(CMD_ADD, 64'h2);
    queue_word(CMD_CLEAR, '1);
    queue_word(CMD_CLEAR, 64'h0);
    queue_word(CMD_QUERY, 64'h1);
    queue_word(CMD_REMOVE, 64'h1);

    // fill the store to the brim, then beyond, then remove absent keys and clear
    for (int i = 0; i < CAP; i++) queue_word(CMD_ADD, {$urandom, $urandom});
    for (int i = 0; i < 4; i++) queue_word(CMD_ADD, rand_key());
    for (int i = 0; i < 3; i++) queue_word(CMD_REMOVE, rand_key());
    queue_word(CMD_CLEAR, rand_key());

    // random mix in three idle phases
    for (int p = 0; p < 3; p++) begin
      while (pending.size() > 0 || expected.size() > 0 || start) @(posedge clk);
      phase = p;
      live_keys.delete();
      for (int i = 0; i < 140; i++) begin
        case ($urandom_range(0, 99)) inside
          [0:44]: begin
            k = (live_keys.size() > 0 && $urandom_range(0, 3) == 0) ?
                live_keys[$urandom_range(0, live_keys.size() - 1)] : rand_key();
            queue_word(CMD_ADD, k);
            live_keys.push_back(k);
          end
          [45:69]: queue_word(CMD_QUERY, pool_key());
          [70:97]: queue_word(CMD_REMOVE, pool_key());
          default: begin
            queue_word(CMD_CLEAR, rand_key());
            live_keys.delete();
          end
        endcase
      end
    end
    while (pending.size() > 0 || expected.size() > 0 || start) @(posedge clk);
    repeat (200) @(posedge clk);
    if (errors == 0 && expected.size() == 0) $display("chained_hash_set_test: clean");
    else $display("chained_hash_set_test: errors");
    $finish;
  end

endmodule
